// ===== src/mset_pkg.sv =====
// Shared constants, codes and types for the multi-slot event timer.
package mset_pkg;

  // Parameter defaults
  localparam int SLOT_COUNT_DEF = 8;
  localparam int TICK_STEP_DEF  = 10;

  // Field widths
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 3;
  localparam int TMO_W   = 32;
  localparam int CODE_W  = 16;
  localparam int OFF_W   = 8;
  localparam int CLK_W   = 32;
  localparam int CNT_W   = 34;

  // Operations
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 3'd1;
  localparam logic [OP_W-1:0] OP_DISARM = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd3;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd4;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd5;

  // Slot status
  localparam logic [1:0] ST_UNUSED = 2'h0;
  localparam logic [1:0] ST_ARMED  = 2'h1;
  localparam logic [1:0] ST_PAUSED = 2'h2;

  // Result kinds
  localparam logic RK_EVENT = 1'b0;
  localparam logic RK_ARM   = 1'b1;

  // Per-slot settings held in the settings RAM
  typedef struct packed {
    logic              rep;
    logic [TMO_W-1:0]  timeout;
    logic [CODE_W-1:0] code;
  } slot_cfg_t;

endpackage

// ===== src/mset_in_if.sv =====
// Input channel of the event timer: valid/ready plus one command beat.
interface mset_in_if;
  logic                          valid;
  logic                          ready;
  logic [mset_pkg::OP_W-1:0]     operation;
  logic [mset_pkg::SLOT_W-1:0]   slot_index;
  logic [mset_pkg::TMO_W-1:0]    period_ms;
  logic [mset_pkg::CODE_W-1:0]   event_code;
  logic                          repeat_flag;
  logic                          start_now;
  logic [mset_pkg::OFF_W-1:0]    elapsed_offset_ms;

  modport source (
    output valid, operation, slot_index, period_ms, event_code, repeat_flag, start_now,
           elapsed_offset_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, slot_index, period_ms, event_code, repeat_flag, start_now,
           elapsed_offset_ms,
    output ready
  );
endinterface

// ===== src/mset_out_if.sv =====
// Result channel of the event timer: valid/ready plus one result beat.
interface mset_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [mset_pkg::CODE_W-1:0]   fired_event_code;
  logic [mset_pkg::CLK_W-1:0]    time_stamp_ms;
  logic [mset_pkg::SLOT_W-1:0]   result_slot;
  logic                          no_free_slot;
  logic                          last_of_run;

  modport source (
    output valid, result_kind, fired_event_code, time_stamp_ms, result_slot, no_free_slot,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, fired_event_code, time_stamp_ms, result_slot, no_free_slot,
           last_of_run,
    output ready
  );
endinterface

// ===== src/mset_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module mset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/multi_slot_event_timer.sv =====
// Multi-slot event timer: settings and counters in two RAMs, status in registers.
// Tick: after the accept, one slot per cycle unless a fired slot stalls on the output
//   (counter RAM read port feeds the evaluation), then a flush state for the last event.
// Arm: a free-slot search from slot 0 follows the accept cycle.
// Disarm, reset, pause, resume and unknown codes complete in the accept cycle.
// Reset (rst_n low, synchronous): clock and all slots unused; no clearing pass.
module multi_slot_event_timer #(
  parameter int SLOT_COUNT   = mset_pkg::SLOT_COUNT_DEF,
  parameter int TICK_STEP_MS = mset_pkg::TICK_STEP_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mset_in_if.sink    in_chan,
  mset_out_if.source out_chan
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = mset_pkg::CNT_W;
  localparam int CFG_W = $bits(mset_pkg::slot_cfg_t);
  localparam logic [IDX_W-1:0]            LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]            STEP_CNT = CNT_W'(TICK_STEP_MS);
  localparam logic [mset_pkg::OFF_W-1:0]  STEP_OFF = mset_pkg::OFF_W'(TICK_STEP_MS);
  localparam logic [mset_pkg::CLK_W-1:0]  STEP_CLK = mset_pkg::CLK_W'(TICK_STEP_MS);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TICK  = 2'd1;
  localparam logic [1:0] S_ARM   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [mset_pkg::CLK_W-1:0] clock_r, clock_nxt;
  logic [1:0]       status_r [SLOT_COUNT];
  logic [1:0]       status_nxt [SLOT_COUNT];

  // Pending fired event: held back one slot so the last one can be marked
  logic                         pend_v_r, pend_v_nxt;
  logic [mset_pkg::CODE_W-1:0]  pend_code_r, pend_code_nxt;
  logic [mset_pkg::SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;

  // Output register
  logic                         out_v_r, out_v_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [mset_pkg::CODE_W-1:0]  out_code_r, out_code_nxt;
  logic [mset_pkg::CLK_W-1:0]   out_ts_r, out_ts_nxt;
  logic [mset_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                         out_nofree_r, out_nofree_nxt;
  logic                         out_last_r, out_last_nxt;

  // Captured arm command
  logic [mset_pkg::TMO_W-1:0]   arm_tmo_r, arm_tmo_nxt;
  logic [mset_pkg::CODE_W-1:0]  arm_code_r, arm_code_nxt;
  logic                         arm_rep_r, arm_rep_nxt;
  logic                         arm_start_r, arm_start_nxt;
  logic [mset_pkg::OFF_W-1:0]   arm_off_r, arm_off_nxt;

  // RAM ports
  logic                 cfg_we;
  mset_pkg::slot_cfg_t  cfg_wdata;
  logic [CFG_W-1:0]     cfg_rbits;
  mset_pkg::slot_cfg_t  cfg_rd;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [CNT_W-1:0]     cnt_rd;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;

  logic                        in_fire;
  logic                        out_free;
  logic                        idx_ok;
  logic [IDX_W-1:0]            slot_sel;
  logic [mset_pkg::OFF_W-1:0]  off_src;
  logic [mset_pkg::OFF_W-1:0]  off_sat;
  logic [CNT_W-1:0]            seed_cnt;

  // Slot evaluation
  logic [1:0]       scan_st;
  logic             armed;
  logic             tmo_zero;
  logic [CNT_W-1:0] cnt_sum;
  logic [CNT_W:0]   cnt_diff;
  logic             reached;
  logic             fire;
  logic             cnt_upd;
  logic             one_shot_done;
  logic [CNT_W-1:0] cnt_new;
  logic             tick_go;

  mset_ram #(.WIDTH(CFG_W), .DEPTH(SLOT_COUNT)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (scan_r),
    .wdata (cfg_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cfg_rbits)
  );

  mset_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rd)
  );

  assign cfg_rd = cfg_rbits;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_v_r || out_chan.ready;

  // Commands aimed past the table are dropped
  assign idx_ok   = (32'(in_chan.slot_index) < SLOT_COUNT);
  assign slot_sel = IDX_W'(in_chan.slot_index);

  // Counter seed: offset saturates at one step, seed = offset - step (<= 0)
  assign off_src  = (state_r == S_ARM) ? arm_off_r : in_chan.elapsed_offset_ms;
  assign off_sat  = (off_src > STEP_OFF) ? STEP_OFF : off_src;
  assign seed_cnt = CNT_W'(off_sat) - STEP_CNT;

  // One slot per cycle unless stalled: RAM data for scan_r arrives this cycle.
  // Counter compare is signed; diff sign bit clear means counter >= timeout.
  assign scan_st       = status_r[scan_r];
  assign armed         = (scan_st == mset_pkg::ST_ARMED);
  assign tmo_zero      = (cfg_rd.timeout == '0);
  assign cnt_sum       = cnt_rd + STEP_CNT;
  assign cnt_diff      = {cnt_sum[CNT_W-1], cnt_sum} - {3'b000, cfg_rd.timeout};
  assign reached       = !cnt_diff[CNT_W];
  assign fire          = armed && (tmo_zero || reached);
  assign cnt_upd       = armed && !tmo_zero;
  assign one_shot_done = cnt_upd && reached && !cfg_rd.rep;
  assign cnt_new       = (reached && cfg_rd.rep) ? cnt_diff[CNT_W-1:0] : cnt_sum;

  // A fired slot stalls only when the pending beat cannot move out
  assign tick_go = (state_r == S_TICK) && !(fire && pend_v_r && !out_free);

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    clock_nxt      = clock_r;
    status_nxt     = status_r;
    pend_v_nxt     = pend_v_r;
    pend_code_nxt  = pend_code_r;
    pend_slot_nxt  = pend_slot_r;
    out_v_nxt      = out_v_r && !out_chan.ready;
    out_kind_nxt   = out_kind_r;
    out_code_nxt   = out_code_r;
    out_ts_nxt     = out_ts_r;
    out_slot_nxt   = out_slot_r;
    out_nofree_nxt = out_nofree_r;
    out_last_nxt   = out_last_r;
    arm_tmo_nxt    = arm_tmo_r;
    arm_code_nxt   = arm_code_r;
    arm_rep_nxt    = arm_rep_r;
    arm_start_nxt  = arm_start_r;
    arm_off_nxt    = arm_off_r;
    cfg_we         = 1'b0;
    cfg_wdata      = '{rep: arm_rep_r, timeout: arm_tmo_r, code: arm_code_r};
    cnt_we         = 1'b0;
    cnt_waddr      = scan_r;
    cnt_wdata      = cnt_new;
    rd_en          = 1'b0;
    rd_addr        = scan_r + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.operation)
            mset_pkg::OP_TICK: begin
              clock_nxt = clock_r + STEP_CLK;
              scan_nxt  = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_TICK;
            end
            mset_pkg::OP_ARM: begin
              arm_tmo_nxt   = in_chan.period_ms;
              arm_code_nxt  = in_chan.event_code;
              arm_rep_nxt   = in_chan.repeat_flag;
              arm_start_nxt = in_chan.start_now;
              arm_off_nxt   = in_chan.elapsed_offset_ms;
              scan_nxt      = '0;
              state_nxt     = S_ARM;
            end
            mset_pkg::OP_DISARM: begin
              if (idx_ok) begin
                status_nxt[slot_sel] = mset_pkg::ST_UNUSED;
              end
            end
            mset_pkg::OP_RESET: begin
              if (idx_ok) begin
                cnt_we               = 1'b1;
                cnt_waddr            = slot_sel;
                cnt_wdata            = seed_cnt;
                status_nxt[slot_sel] = mset_pkg::ST_ARMED;
              end
            end
            mset_pkg::OP_PAUSE: begin
              if (idx_ok) begin
                status_nxt[slot_sel] = mset_pkg::ST_PAUSED;
              end
            end
            mset_pkg::OP_RESUME: begin
              if (idx_ok) begin
                status_nxt[slot_sel] = mset_pkg::ST_ARMED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TICK: begin
        if (tick_go) begin
          cnt_we = cnt_upd;
          if (one_shot_done) begin
            status_nxt[scan_r] = mset_pkg::ST_UNUSED;
          end
          if (fire) begin
            // Earlier fired slot is now known not to be the last
            if (pend_v_r) begin
              out_v_nxt      = 1'b1;
              out_kind_nxt   = mset_pkg::RK_EVENT;
              out_code_nxt   = pend_code_r;
              out_ts_nxt     = clock_r;
              out_slot_nxt   = pend_slot_r;
              out_nofree_nxt = 1'b0;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_code_nxt = cfg_rd.code;
            pend_slot_nxt = mset_pkg::SLOT_W'(scan_r);
          end
          if (scan_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            scan_nxt = scan_r + 1'b1;
            rd_en    = 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt      = 1'b1;
          out_kind_nxt   = mset_pkg::RK_EVENT;
          out_code_nxt   = pend_code_r;
          out_ts_nxt     = clock_r;
          out_slot_nxt   = pend_slot_r;
          out_nofree_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_ARM: begin
        if (scan_st == mset_pkg::ST_UNUSED || scan_r == LAST_IDX) begin
          if (out_free) begin
            out_v_nxt      = 1'b1;
            out_kind_nxt   = mset_pkg::RK_ARM;
            out_code_nxt   = '0;
            out_ts_nxt     = clock_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
            if (scan_st == mset_pkg::ST_UNUSED) begin
              cfg_we             = 1'b1;
              cnt_we             = 1'b1;
              cnt_wdata          = seed_cnt;
              status_nxt[scan_r] = arm_start_r ? mset_pkg::ST_ARMED : mset_pkg::ST_PAUSED;
              out_slot_nxt       = mset_pkg::SLOT_W'(scan_r);
              out_nofree_nxt     = 1'b0;
            end else begin
              out_slot_nxt   = '0;
              out_nofree_nxt = 1'b1;
            end
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      scan_r   <= '0;
      clock_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status_r[i] <= mset_pkg::ST_UNUSED;
      end
    end else begin
      state_r  <= state_nxt;
      scan_r   <= scan_nxt;
      clock_r  <= clock_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_code_r  <= pend_code_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_kind_r   <= out_kind_nxt;
    out_code_r   <= out_code_nxt;
    out_ts_r     <= out_ts_nxt;
    out_slot_r   <= out_slot_nxt;
    out_nofree_r <= out_nofree_nxt;
    out_last_r   <= out_last_nxt;
    arm_tmo_r    <= arm_tmo_nxt;
    arm_code_r   <= arm_code_nxt;
    arm_rep_r    <= arm_rep_nxt;
    arm_start_r  <= arm_start_nxt;
    arm_off_r    <= arm_off_nxt;
  end

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_v_r;
  assign out_chan.result_kind      = out_kind_r;
  assign out_chan.fired_event_code = out_code_r;
  assign out_chan.time_stamp_ms    = out_ts_r;
  assign out_chan.result_slot      = out_slot_r;
  assign out_chan.no_free_slot     = out_nofree_r;
  assign out_chan.last_of_run      = out_last_r;

  // The held-back event must be gone before the next command is taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending event left behind at idle");

  a_arm_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ARM |-> !pend_v_r)
    else $error("pending event during arm search");

  // An arm reply is always the single, final beat of its command
  a_arm_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_kind_r == mset_pkg::RK_ARM |-> out_last_r)
    else $error("arm reply not marked last");

  a_tick_clock: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.operation == mset_pkg::OP_TICK
    |=> clock_r == $past(clock_r) + STEP_CLK)
    else $error("tick did not advance the clock by one step");

endmodule

// ===== test/tb_multi_slot_event_timer.sv =====
// Self-checking testbench for the multi-slot event timer with random handshakes.
`timescale 1ns / 100ps

module tb_multi_slot_event_timer;

  localparam int SLOTS       = mset_pkg::SLOT_COUNT_DEF;
  localparam int STEP_MS     = mset_pkg::TICK_STEP_DEF;
  localparam int OP_W        = mset_pkg::OP_W;
  localparam int SLOT_W      = mset_pkg::SLOT_W;
  localparam int TMO_W       = mset_pkg::TMO_W;
  localparam int CODE_W      = mset_pkg::CODE_W;
  localparam int OFF_W       = mset_pkg::OFF_W;
  localparam int CLK_W       = mset_pkg::CLK_W;
  localparam int CNT_W       = mset_pkg::CNT_W;
  localparam int RAND_ITEMS  = 150;
  // Leave room after the last result for stray beats.
  localparam int DRAIN       = 2 * (SLOTS + 2) + 10;
  // Far above the longest legal quiet stretch (tick walk plus a sink stall).
  localparam int QUIET_LIMIT = 2000;

  // Codes the block must ignore.
  localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

  // Two copies of the model state: the stimulus view runs ahead while items are
  // queued (so only slots with written settings are revived), the check view
  // steps on each accepted command beat and feeds the expected-result queue.
  localparam int GEN_VIEW = 0;
  localparam int CHK_VIEW = 1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TMO_W-1:0]  tmo;
    logic [CODE_W-1:0] code;
    logic              rep;
    logic              start;
    logic [OFF_W-1:0]  off;
    int unsigned       gap;    // idle cycles before this beat is offered
  } timer_cmd_t;

  typedef struct {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [CLK_W-1:0]  stamp;
    logic [SLOT_W-1:0] slot;
    logic              nofree;
    logic              last;
  } timer_evt_t;

  logic clk;
  logic rst_n;

  mset_in_if  in_chan();
  mset_out_if out_chan();

  multi_slot_event_timer #(
    .SLOT_COUNT  (SLOTS),
    .TICK_STEP_MS(STEP_MS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Model state, indexed by view.
  logic [CLK_W-1:0]         ms_clock     [2];
  logic [1:0]               slot_state   [2][SLOTS];
  logic [CODE_W-1:0]        slot_code    [2][SLOTS];
  logic [TMO_W-1:0]         slot_period  [2][SLOTS];
  logic signed [CNT_W-1:0]  slot_count   [2][SLOTS];
  logic                     slot_rep     [2][SLOTS];
  logic                     slot_touched [2][SLOTS];

  timer_cmd_t  cmd_q[$];        // commands not yet offered
  timer_evt_t  due_results[$];  // predicted results not yet seen

  int unsigned cmds_total   = 0;
  int unsigned cmds_taken   = 0;
  int unsigned op_hits [8]  = '{default: 0};
  int unsigned beats_seen   = 0;
  int unsigned fired_seen   = 0;
  int unsigned replies_seen = 0;
  int unsigned full_seen    = 0;
  int unsigned errors       = 0;

  int unsigned idle_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Counter seed from the sub-tick phase: min(off, step) - step.
  function automatic logic signed [CNT_W-1:0] phase_seed(input logic [OFF_W-1:0] off);
    int p;
    p = (off > STEP_MS) ? STEP_MS : int'(off);
    return CNT_W'(p - STEP_MS);
  endfunction

  // One command through the timer model; results go to due_results in check view.
  function automatic void apply_command(input int v, input timer_cmd_t c);
    timer_evt_t              run[$];
    timer_evt_t              r;
    int                      hit;
    logic                    fire;
    logic signed [CNT_W-1:0] lim;
    hit      = -1;
    r.kind   = mset_pkg::RK_EVENT;
    r.code   = '0;
    r.stamp  = '0;
    r.slot   = '0;
    r.nofree = 1'b0;
    r.last   = 1'b0;
    case (c.op)
      mset_pkg::OP_TICK: begin
        ms_clock[v] = ms_clock[v] + CLK_W'(STEP_MS);
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state[v][i] == mset_pkg::ST_ARMED) begin
            fire = 1'b0;
            if (slot_period[v][i] == '0) begin
              // zero timeout: fires every tick, counter untouched, never frees
              fire = 1'b1;
            end else begin
              slot_count[v][i] = slot_count[v][i] + CNT_W'(STEP_MS);
              lim = $signed({{(CNT_W-TMO_W){1'b0}}, slot_period[v][i]});
              // signed compare: a negative seed cannot fire early
              if (slot_count[v][i] >= lim) begin
                fire = 1'b1;
                if (slot_rep[v][i])
                  slot_count[v][i] = slot_count[v][i] - lim;
                else
                  slot_state[v][i] = mset_pkg::ST_UNUSED;
              end
            end
            if (fire) begin
              r.kind  = mset_pkg::RK_EVENT;
              r.code  = slot_code[v][i];
              r.stamp = ms_clock[v];
              r.slot  = i[SLOT_W-1:0];
              run.push_back(r);
            end
          end
        end
      end
      mset_pkg::OP_ARM: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (slot_state[v][i] == mset_pkg::ST_UNUSED) hit = i;
        r.kind  = mset_pkg::RK_ARM;
        r.stamp = ms_clock[v];
        if (hit >= 0) begin
          slot_code[v][hit]    = c.code;
          slot_period[v][hit]  = c.tmo;
          slot_rep[v][hit]     = c.rep;
          slot_count[v][hit]   = phase_seed(c.off);
          slot_state[v][hit]   = c.start ? mset_pkg::ST_ARMED : mset_pkg::ST_PAUSED;
          slot_touched[v][hit] = 1'b1;
          r.slot = hit[SLOT_W-1:0];
        end else begin
          r.nofree = 1'b1;
        end
        run.push_back(r);
      end
      mset_pkg::OP_DISARM: if (c.slot < SLOTS) slot_state[v][c.slot] = mset_pkg::ST_UNUSED;
      mset_pkg::OP_RESET: begin
        if (c.slot < SLOTS) begin
          slot_count[v][c.slot] = phase_seed(c.off);
          slot_state[v][c.slot] = mset_pkg::ST_ARMED;
        end
      end
      mset_pkg::OP_PAUSE:  if (c.slot < SLOTS) slot_state[v][c.slot] = mset_pkg::ST_PAUSED;
      mset_pkg::OP_RESUME: if (c.slot < SLOTS) slot_state[v][c.slot] = mset_pkg::ST_ARMED;
      default: ;
    endcase
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    if (v == CHK_VIEW)
      foreach (run[k]) due_results.push_back(run[k]);
  endfunction

  // Steps the stimulus view and queues the beat with its lead-in gap.
  function automatic void queue_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                    input logic [TMO_W-1:0] tmo, input logic [CODE_W-1:0] code,
                                    input logic rep, input logic start,
                                    input logic [OFF_W-1:0] off);
    timer_cmd_t c;
    c.op    = op;
    c.slot  = slot;
    c.tmo   = tmo;
    c.code  = code;
    c.rep   = rep;
    c.start = start;
    c.off   = off;
    // every fourth stretch of 24 beats runs back to back
    c.gap   = ((cmds_total / 24) % 4 == 3) ? 0 : $urandom_range(0, 9);
    apply_command(GEN_VIEW, c);
    cmd_q.push_back(c);
    cmds_total++;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Command driver: offers queued beats, predicts on every accepted one.
  always @(posedge clk) begin : drive_cmds
    timer_cmd_t nxt;
    timer_cmd_t seen;
    if (!rst_n) begin
      in_chan.valid             <= 1'b0;
      in_chan.operation         <= '0;
      in_chan.slot_index        <= '0;
      in_chan.period_ms         <= '0;
      in_chan.event_code        <= '0;
      in_chan.repeat_flag       <= 1'b0;
      in_chan.start_now         <= 1'b0;
      in_chan.elapsed_offset_ms <= '0;
      idle_left                 <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        seen.op    = in_chan.operation;
        seen.slot  = in_chan.slot_index;
        seen.tmo   = in_chan.period_ms;
        seen.code  = in_chan.event_code;
        seen.rep   = in_chan.repeat_flag;
        seen.start = in_chan.start_now;
        seen.off   = in_chan.elapsed_offset_ms;
        seen.gap   = 0;
        apply_command(CHK_VIEW, seen);
        op_hits[seen.op]++;
        cmds_taken++;   // after the prediction, so the end check sees it queued
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (idle_left != 0) begin
          idle_left     <= idle_left - 1;
          in_chan.valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (cmd_q[0].gap != 0) begin
          // this cycle is the first idle one
          idle_left     <= cmd_q[0].gap - 1;
          cmd_q[0].gap   = 0;
          in_chan.valid <= 1'b0;
        end else begin
          nxt = cmd_q.pop_front();
          in_chan.valid             <= 1'b1;
          in_chan.operation         <= nxt.op;
          in_chan.slot_index        <= nxt.slot;
          in_chan.period_ms         <= nxt.tmo;
          in_chan.event_code        <= nxt.code;
          in_chan.repeat_flag       <= nxt.rep;
          in_chan.start_now         <= nxt.start;
          in_chan.elapsed_offset_ms <= nxt.off;
        end
      end
    end
  end

  // Result monitor: random sink stalls, in-order compare against the model.
  always @(posedge clk) begin : take_results
    timer_evt_t  want;
    int unsigned pause_len;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got kind %0d slot %0d",
                   $time, out_chan.result_kind, out_chan.result_slot);
          $display("%0t:   code %0h stamp %0d", $time, out_chan.fired_event_code,
                   out_chan.time_stamp_ms);
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.kind, out_chan.result_kind);
          check_field("fired_event_code", want.code, out_chan.fired_event_code);
          check_field("time_stamp_ms", want.stamp, out_chan.time_stamp_ms);
          check_field("result_slot", want.slot, out_chan.result_slot);
          check_field("no_free_slot", want.nofree, out_chan.no_free_slot);
          check_field("last_of_run", want.last, out_chan.last_of_run);
        end
        if (out_chan.result_kind == mset_pkg::RK_EVENT) fired_seen++;
        else replies_seen++;
        if (out_chan.no_free_slot) full_seen++;
        beats_seen++;
        // one stretch in four takes beats without stalling
        pause_len       = ((beats_seen / 20) % 4 == 1) ? 0 : $urandom_range(0, 9);
        stall_left     <= pause_len;
        out_chan.ready <= (pause_len == 0);
      end else if (stall_left != 0) begin
        stall_left     <= stall_left - 1;
        out_chan.ready <= (stall_left == 1);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, due_results.size());
      $display("tb_multi_slot_event_timer NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       rand_done;
    int unsigned       pick;
    int unsigned       sel;
    int                pool[$];
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TMO_W-1:0]  tmo;
    logic [CODE_W-1:0] code;
    logic              rep;
    logic              start;
    logic [OFF_W-1:0]  off;

    rst_n = 1'b0;
    for (int v = 0; v < 2; v++) begin
      ms_clock[v] = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[v][i]   = mset_pkg::ST_UNUSED;
        slot_code[v][i]    = '0;
        slot_period[v][i]  = '0;
        slot_count[v][i]   = '0;
        slot_rep[v][i]     = 1'b0;
        slot_touched[v][i] = 1'b0;
      end
    end

    // ---- directed ----
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);                  // quiet tick
    queue_cmd(OP_UNDEF_A, '1, '1, '1, 1, 1, '1);                     // ignored codes
    queue_cmd(OP_UNDEF_B, '0, '0, '0, 0, 0, '0);
    queue_cmd(mset_pkg::OP_ARM, 0, '0, 16'hFFFF, 1, 1, 0);           // slot 0: every tick
    queue_cmd(mset_pkg::OP_ARM, 0, 5, 16'h1234, 0, 1, 0);            // slot 1: seed -10
    queue_cmd(mset_pkg::OP_ARM, 0, STEP_MS, 16'h0000, 1, 1, 8'hFF);  // slot 2: offset saturates
    queue_cmd(mset_pkg::OP_ARM, 0, 32'hFFFF_FFFF, 16'hA5A5, 0, 0, STEP_MS); // slot 3: paused
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);                  // one-shot slot 1 frees
    queue_cmd(mset_pkg::OP_PAUSE, 2, 0, 0, 0, 0, 0);
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);                  // paused counter held
    queue_cmd(mset_pkg::OP_RESUME, 2, 0, 0, 0, 0, 0);
    queue_cmd(mset_pkg::OP_RESET, 3, 0, 0, 0, 0, 7);
    queue_cmd(mset_pkg::OP_DISARM, 1, 0, 0, 0, 0, 0);                // already free
    queue_cmd(mset_pkg::OP_PAUSE, 1, 0, 0, 0, 0, 0);                 // free slot goes paused
    queue_cmd(mset_pkg::OP_RESUME, 1, 0, 0, 0, 0, 0);                // and comes back armed
    queue_cmd(mset_pkg::OP_ARM, 0, 20, 16'h8001, 1, 1, 3);
    queue_cmd(mset_pkg::OP_ARM, 0, 32'h8000_0000, 16'h5A5A, 1, 1, 0);
    queue_cmd(mset_pkg::OP_ARM, 0, 30, 16'h00FF, 0, 1, 8'hFF);
    queue_cmd(mset_pkg::OP_ARM, 0, '0, 16'h7FFF, 0, 1, 0);           // one-shot, zero timeout
    queue_cmd(mset_pkg::OP_ARM, 0, 40, 16'hBEEF, 1, 1, 1);           // table full
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
    queue_cmd(mset_pkg::OP_DISARM, 0, 0, 0, 0, 0, 0);
    queue_cmd(mset_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);

    // ---- random: mostly ticks and arms with short timeouts, noise in idle fields ----
    rand_done = 0;
    while (rand_done < RAND_ITEMS) begin
      pick  = $urandom_range(0, 99);
      slot  = SLOT_W'($urandom_range(0, SLOTS - 1));
      tmo   = $urandom;
      code  = CODE_W'($urandom);
      rep   = 1'($urandom_range(0, 1));
      start = 1'($urandom_range(0, 1));
      off   = ($urandom_range(0, 1) != 0) ? OFF_W'($urandom_range(0, STEP_MS + 2))
                                          : OFF_W'($urandom_range(0, 255));
      pool.delete();
      for (int i = 0; i < SLOTS; i++)
        if (slot_touched[GEN_VIEW][i]) pool.push_back(i);
      if (pick < 40) begin
        op = mset_pkg::OP_TICK;
      end else if (pick < 68) begin
        op    = mset_pkg::OP_ARM;
        start = ($urandom_range(0, 9) != 0);
        sel   = $urandom_range(0, 9);
        if (sel == 0)      tmo = '0;
        else if (sel <= 6) tmo = $urandom_range(1, 80);
        else if (sel <= 8) tmo = TMO_W'($urandom_range(1, 8) * STEP_MS);
      end else if (pick < 78) begin
        op = mset_pkg::OP_DISARM;
      end else if (pick < 85) begin
        op = mset_pkg::OP_RESET;
      end else if (pick < 91) begin
        op = mset_pkg::OP_PAUSE;
      end else if (pick < 97) begin
        op = mset_pkg::OP_RESUME;
      end else begin
        op = ($urandom_range(0, 1) != 0) ? OP_UNDEF_A : OP_UNDEF_B;
      end
      // never revive a slot whose settings were never written
      if (op == mset_pkg::OP_RESET || op == mset_pkg::OP_RESUME) begin
        if (pool.size() == 0) op = mset_pkg::OP_TICK;
        else slot = SLOT_W'(pool[$urandom_range(0, pool.size() - 1)]);
      end
      queue_cmd(op, slot, tmo, code, rep, start, off);
      if (op != OP_UNDEF_A && op != OP_UNDEF_B) rand_done++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (cmds_taken != cmds_total);
    do @(posedge clk); while (due_results.size() != 0);
    repeat (DRAIN) @(posedge clk);

    $display("commands: %0d (tick %0d, arm %0d, disarm %0d, reset %0d, pause %0d, resume %0d)",
             cmds_taken, op_hits[mset_pkg::OP_TICK], op_hits[mset_pkg::OP_ARM],
             op_hits[mset_pkg::OP_DISARM], op_hits[mset_pkg::OP_RESET],
             op_hits[mset_pkg::OP_PAUSE], op_hits[mset_pkg::OP_RESUME]);
    $display("results: %0d fired events, %0d arm replies (%0d with the table full)",
             fired_seen, replies_seen, full_seen);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_multi_slot_event_timer OK");
    end else begin
      $display("tb_multi_slot_event_timer NOT OK");
    end
    $finish;
  end

endmodule
